// ----- sv/stereo_disparity_range_assert.svh -----
// assertion macros shared by the disparity range modules
// depends on nothing; included inside module bodies
`ifndef STEREO_DISPARITY_RANGE_ASSERT_SVH
`define STEREO_DISPARITY_RANGE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SDR_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define SDR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- sv/sdr_pkg.sv -----
// shared types and constants for the stereo disparity range block
// no dependencies
`default_nettype none
package sdr_pkg;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int DISP_FRAC_DEF   = 8;
   localparam int CSR_IDX_W       = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LEFT_NUM  = 3'd0,
      REG_LEFT_DEN  = 3'd1,
      REG_LEFT_OFS  = 3'd2,
      REG_RIGHT_NUM = 3'd3,
      REG_RIGHT_DEN = 3'd4,
      REG_RIGHT_OFS = 3'd5
   } reg_idx_type;

   localparam logic [63:0] NUM_RESET = 64'd4503599627370496;
   localparam logic [63:0] DEN_RESET = 64'd0;
   localparam logic [63:0] OFS_RESET = 64'd268435456;

   // one classified match handed from front to back
   typedef struct packed {
      logic        ok;
      logic signed [31:0] disp;
      logic        last;
   } match_type;
endpackage
`default_nettype wire

// ----- sv/sdr_front.sv -----
// front: maps both x coordinates through their homographies and forms the disparity
// uses sdr_pkg; one shared multiplier and one restoring divider step per cycle
`default_nettype none
module sdr_front #(
   parameter int COORD_WIDTH = sdr_pkg::COORD_WIDTH_DEF,
   parameter int DISP_FRAC   = sdr_pkg::DISP_FRAC_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [COORD_WIDTH-1:0] left_x,
   input  wire logic [COORD_WIDTH-1:0] left_y,
   input  wire logic [COORD_WIDTH-1:0] right_x,
   input  wire logic [COORD_WIDTH-1:0] right_y,
   input  wire logic                   last_in,
   input  wire logic [63:0]            regs [6],
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output sdr_pkg::match_type          out_item
);
   import sdr_pkg::*;
   `include "stereo_disparity_range_assert.svh"

   localparam logic [63:0] CAP = 64'd1 << 40;
   localparam int FB = 8 + DISP_FRAC;
   localparam int STEP_W = 7;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_MAG  = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_FRAC = 7'b0010000,
      S_SIDE = 7'b0100000,
      S_OUT  = 7'b1000000
   } fstate_type;

   fstate_type         state_ff, state_in;
   logic [COORD_WIDTH-1:0] lx_ff, ly_ff, rx_ff, ry_ff, lx_in, ly_in, rx_in, ry_in;
   logic               last_ff, last_in_r;
   logic               side_ff, side_in;       // 0 left, 1 right
   logic [1:0]         mstep_ff, mstep_in;
   logic [63:0]        num_ff, num_in, den_ff, den_in;
   logic [63:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               neg_ff, neg_in, zero_ff, zero_in;
   logic signed [63:0] xl_ff, xl_in;
   logic               okl_ff, okl_in;
   logic               ov_ff, ov_in;
   match_type          item_ff, item_in;

   logic [63:0] nreg, dreg, oreg;
   logic [COORD_WIDTH-1:0] cx, cy;
   logic signed [31:0] ca;
   logic [COORD_WIDTH-1:0] cc;
   logic signed [63:0] prod;
   logic signed [64:0] dfull;
   logic signed [63:0] xr_s;

   always_comb begin
      nreg = side_ff ? regs[REG_RIGHT_NUM] : regs[REG_LEFT_NUM];
      dreg = side_ff ? regs[REG_RIGHT_DEN] : regs[REG_LEFT_DEN];
      oreg = side_ff ? regs[REG_RIGHT_OFS] : regs[REG_LEFT_OFS];
      cx = side_ff ? rx_ff : lx_ff;
      cy = side_ff ? ry_ff : ly_ff;
      case (mstep_ff)
         2'd0:    begin ca = nreg[63:32]; cc = cx; end
         2'd1:    begin ca = nreg[31:0];  cc = cy; end
         2'd2:    begin ca = dreg[63:32]; cc = cx; end
         default: begin ca = dreg[31:0];  cc = cy; end
      endcase
      prod = 64'(ca * $signed({1'b0, cc}));
      xr_s = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      dfull = 65'(xl_ff) - 65'(xr_s);
   end

   always_comb begin
      state_in = state_ff;
      lx_in = lx_ff; ly_in = ly_ff; rx_in = rx_ff; ry_in = ry_ff;
      last_in_r = last_ff; side_in = side_ff; mstep_in = mstep_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; zero_in = zero_ff;
      xl_in = xl_ff; okl_in = okl_ff; ov_in = ov_ff; item_in = item_ff;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               lx_in = left_x; ly_in = left_y; rx_in = right_x; ry_in = right_y;
               last_in_r = last_in; side_in = 1'b0; mstep_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            unique case (mstep_ff)
               2'd0: num_in = prod + ({{32{oreg[63]}}, oreg[63:32]} << 4);
               2'd1: num_in = num_ff + prod;
               2'd2: den_in = prod + ({{32{oreg[31]}}, oreg[31:0]} << 4);
               default: den_in = den_ff + prod;
            endcase
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd3) state_in = S_MAG;
         end
         S_MAG: begin
            neg_in = num_ff[63] ^ den_ff[63];
            num_in = num_ff[63] ? -num_ff : num_ff;
            den_in = den_ff[63] ? -den_ff : den_ff;
            zero_in = (den_ff == 64'd0);
            rem_in = 64'd0; quo_in = 64'd0; ov_in = 1'b0;
            cnt_in = STEP_W'(64);
            state_in = (den_ff == 64'd0) ? S_SIDE : S_DIV;
         end
         S_DIV: begin
            // one restoring step per cycle over the 64 numerator bits
            rem_in = {rem_ff[62:0], num_ff[63]};
            num_in = {num_ff[62:0], 1'b0};
            if ({1'b0, rem_ff[62:0], num_ff[63]} >= {1'b0, den_ff} || rem_ff[63]) begin
               rem_in = {rem_ff[62:0], num_ff[63]} - den_ff;
               quo_in = {quo_ff[62:0], 1'b1};
            end else quo_in = {quo_ff[62:0], 1'b0};
            if (quo_ff[62:41] != 22'd0 || quo_ff[63]) ov_in = 1'b1;
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               cnt_in = STEP_W'(FB);
               state_in = S_FRAC;
            end
         end
         S_FRAC: begin
            if (ov_ff || quo_ff >= CAP) begin
               quo_in = CAP;
               state_in = S_SIDE;
            end else if (cnt_ff == STEP_W'(0)) begin
               state_in = S_SIDE;
            end else begin
               if (rem_ff >= den_ff - rem_ff) begin
                  rem_in = rem_ff - (den_ff - rem_ff);
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[62:0], 1'b0};
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         S_SIDE: begin
            if (!side_ff) begin
               xl_in = xr_s; okl_in = !zero_ff;
               side_in = 1'b1; mstep_in = 2'd0;
               state_in = S_MUL;
            end else begin
               item_in.ok = okl_ff && !zero_ff;
               item_in.last = last_ff;
               if (dfull > 65'sh7FFFFFFF) item_in.disp = 32'sh7FFFFFFF;
               else if (dfull < -65'sh80000000) item_in.disp = -32'sh80000000;
               else item_in.disp = dfull[31:0];
               state_in = S_OUT;
            end
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      lx_ff <= lx_in; ly_ff <= ly_in; rx_ff <= rx_in; ry_ff <= ry_in;
      last_ff <= last_in_r; side_ff <= side_in; mstep_ff <= mstep_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; zero_ff <= zero_in;
      xl_ff <= xl_in; okl_ff <= okl_in; ov_ff <= ov_in; item_ff <= item_in;
   end

   assign out_valid = (state_ff == S_OUT);
   assign out_item  = item_ff;

   `SDR_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `SDR_ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid)
   `SDR_ASSERT_IMP(a_cap, clock, reset, state_ff == S_SIDE, quo_ff <= CAP || zero_ff)
endmodule
`default_nettype wire

// ----- sv/sdr_back.sv -----
// back: running min and max of the disparity and the bounds result register
// uses sdr_pkg
`default_nettype none
module sdr_back #(
   parameter int DISP_FRAC = sdr_pkg::DISP_FRAC_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sdr_pkg::match_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [33:0]             out_data
);
   import sdr_pkg::*;
   `include "stereo_disparity_range_assert.svh"

   logic signed [31:0] min_ff, min_in, max_ff, max_in;
   logic any_ff, any_in, deg_ff, deg_in;
   logic ov_ff, ov_in;
   logic [33:0] data_ff, data_in;
   logic signed [31:0] nmin, nmax;
   logic signed [32:0] tmin, tmax, bmin, bmax;
   logic take;

   function automatic logic [15:0] sat16(input logic signed [32:0] v);
      if (v > 33'sd32767) return 16'h7FFF;
      else if (v < -33'sd32768) return 16'h8000;
      else return v[15:0];
   endfunction

   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      nmin = min_ff; nmax = max_ff;
      if (in_item.ok) begin
         if (in_item.disp < min_ff) nmin = in_item.disp;
         if (in_item.disp > max_ff) nmax = in_item.disp;
      end
      // truncate toward zero
      tmin = nmin[31] ? -((-33'(nmin)) >>> DISP_FRAC) : (33'(nmin) >>> DISP_FRAC);
      tmax = nmax[31] ? -((-33'(nmax)) >>> DISP_FRAC) : (33'(nmax) >>> DISP_FRAC);
      bmin = nmin[31] ? tmin - 33'sd1 : tmin;
      bmax = nmax[31] ? tmax : tmax + 33'sd1;
      min_in = min_ff; max_in = max_ff; any_in = any_ff; deg_in = deg_ff;
      data_in = data_ff;
      ov_in = ov_ff && !out_ready;
      if (take) begin
         min_in = nmin; max_in = nmax;
         any_in = any_ff || in_item.ok;
         deg_in = deg_ff || !in_item.ok;
         if (in_item.last) begin
            if (any_in) data_in = {1'b0, deg_in, sat16(bmax), sat16(bmin)};
            else data_in = {1'b1, deg_in, 32'd0};
            min_in = 32'sh7FFFFFFF; max_in = -32'sh80000000;
            any_in = 1'b0; deg_in = 1'b0;
            ov_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 32'sh7FFFFFFF; max_ff <= -32'sh80000000;
         any_ff <= 1'b0; deg_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         min_ff <= min_in; max_ff <= max_in;
         any_ff <= any_in; deg_ff <= deg_in; ov_ff <= ov_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = ov_ff;
   assign out_data  = data_ff;

   `SDR_ASSERT_NEXT(a_rsp_hold, clock, reset, out_valid && !out_ready, out_valid)
   `SDR_ASSERT_IMP(a_empty_set, clock, reset, !any_ff, min_ff == 32'sh7FFFFFFF)
   `SDR_ASSERT_NEXT(a_clear, clock, reset, take && in_item.last, !any_ff && !deg_ff)
endmodule
`default_nettype wire

// ----- sv/stereo_disparity_range.sv -----
// top level of the stereo disparity range block: registers, front, back
// uses sdr_pkg, sdr_front, sdr_back
//  channel | dir | tdata / payload
//  req     | in  | left_x, left_y, right_x, right_y; tlast last_match
//  rsp     | out | min_disparity, max_disparity, degenerate_seen, no_valid_match
//  csr     | in  | 3-bit register index, 64-bit value
// an item passes both sides through the one restoring divider that they share, and
// the front holds one item at a time, taking the next only after handing its result on;
// a zero denominator or a saturated quotient shortens that side's division
// the back stalls the front only while a finished result waits for the receiver
// reset is synchronous and restores the csr registers, the control state and the accumulators
`default_nettype none
module stereo_disparity_range #(
   parameter int COORD_WIDTH    = sdr_pkg::COORD_WIDTH_DEF,
   parameter int DISP_FRAC_BITS = sdr_pkg::DISP_FRAC_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // left_x, left_y, right_x, right_y from bit 0 up
   input  wire logic [4*COORD_WIDTH-1:0]   req_tdata,
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // min_disparity, max_disparity, degenerate_seen, no_valid_match, padding
   output logic [39:0]                     rsp_tdata,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [sdr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                csr_data
);
   import sdr_pkg::*;

   logic [63:0] regs_ff [6];
   match_type   f_item;
   logic        f_valid, f_ready;
   logic [33:0] b_data;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= NUM_RESET; regs_ff[1] <= DEN_RESET; regs_ff[2] <= OFS_RESET;
         regs_ff[3] <= NUM_RESET; regs_ff[4] <= DEN_RESET; regs_ff[5] <= OFS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LEFT_NUM:  regs_ff[0] <= csr_data;
            REG_LEFT_DEN:  regs_ff[1] <= csr_data;
            REG_LEFT_OFS:  regs_ff[2] <= csr_data;
            REG_RIGHT_NUM: regs_ff[3] <= csr_data;
            REG_RIGHT_DEN: regs_ff[4] <= csr_data;
            REG_RIGHT_OFS: regs_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   sdr_front #(.COORD_WIDTH(COORD_WIDTH), .DISP_FRAC(DISP_FRAC_BITS)) u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .left_x   (req_tdata[COORD_WIDTH-1:0]),
      .left_y   (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .right_x  (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .right_y  (req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
      .last_in  (req_tlast),
      .regs     (regs_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   sdr_back #(.DISP_FRAC(DISP_FRAC_BITS)) u_back (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(b_data)
   );

   assign rsp_tdata = {6'd0, b_data};
endmodule
`default_nettype wire

// ----- sim/stereo_disparity_range_checker.sv -----
// scoreboard for the stereo disparity range block: watches the csr, req and rsp channels,
// predicts each set's disparity bounds and compares them with the rsp transactions
// uses sdr_pkg for the register indexes and reset values
`default_nettype none
module stereo_disparity_range_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   output int               fail_count,
   output int               pending
);
   import sdr_pkg::*;

   localparam logic [63:0] QUOT_CAP = 64'd1 << 40;

   typedef struct {
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      bit                 degen;
      bit                 none;
   } bounds_type;

   bounds_type bounds_q[$];

   logic [63:0] num_l, den_l, ofs_l, num_r, den_r, ofs_r;
   logic signed [31:0] run_min, run_max;
   bit any_ok, degen_seen;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // x row of one homography, result in Q.8; 0 on a zero denominator
   function automatic bit map_x(input logic [63:0] nxy, dxy, ofs,
                                input logic [15:0] x, y,
                                output logic signed [63:0] res);
      logic [63:0] num, den, n, d, q, r, xe, ye;
      bit nneg, dneg;
      xe  = {48'd0, x};
      ye  = {48'd0, y};
      num = sext32(nxy[63:32]) * xe + sext32(nxy[31:0]) * ye + (sext32(ofs[63:32]) << 4);
      den = sext32(dxy[63:32]) * xe + sext32(dxy[31:0]) * ye + (sext32(ofs[31:0]) << 4);
      nneg = num[63];
      dneg = den[63];
      n = nneg ? 64'd0 - num : num;
      d = dneg ? 64'd0 - den : den;
      res = 0;
      if (d == 0) return 0;
      q = n / d;
      r = n % d;
      if (q >= QUOT_CAP) q = QUOT_CAP;
      for (int i = 0; i < 16 && q < QUOT_CAP; i++) begin
         if (r >= d - r) begin
            r = r - (d - r);
            q = 2 * q + 1;
         end else begin
            r = r + r;
            q = 2 * q;
         end
      end
      if (q > QUOT_CAP) q = QUOT_CAP;
      res = (nneg != dneg) ? -$signed(q) : $signed(q);
      return 1;
   endfunction

   function automatic logic signed [63:0] whole(input logic signed [31:0] v);
      logic [63:0] m;
      m = v[31] ? 64'd0 - 64'(v) : 64'(v);
      m = m >> 8;
      return v[31] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic signed [63:0] xl, xr, d;
      bit okl, okr;
      bounds_type b;
      if (reset) begin
         num_l <= NUM_RESET; den_l <= DEN_RESET; ofs_l <= OFS_RESET;
         num_r <= NUM_RESET; den_r <= DEN_RESET; ofs_r <= OFS_RESET;
         run_min = 32'sh7FFFFFFF;
         run_max = 32'sh80000000;
         any_ok = 0;
         degen_seen = 0;
         fail_count = 0;
         pending = bounds_q.size();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LEFT_NUM:  num_l <= csr_data;
               REG_LEFT_DEN:  den_l <= csr_data;
               REG_LEFT_OFS:  ofs_l <= csr_data;
               REG_RIGHT_NUM: num_r <= csr_data;
               REG_RIGHT_DEN: den_r <= csr_data;
               REG_RIGHT_OFS: ofs_r <= csr_data;
               default: ;
            endcase
         end
         // compare before pushing so a result never matches its own transaction
         if (rsp_tvalid && rsp_tready) begin
            if (bounds_q.size() == 0) begin
               $display("mismatch: result with nothing expected");
               fail_count++;
            end else begin
               b = bounds_q.pop_front();
               if ($signed(rsp_tdata[15:0]) != b.lo)
                  report("min_disparity", $signed(rsp_tdata[15:0]), b.lo);
               if ($signed(rsp_tdata[31:16]) != b.hi)
                  report("max_disparity", $signed(rsp_tdata[31:16]), b.hi);
               if (rsp_tdata[32] != b.degen)
                  report("degenerate_seen", rsp_tdata[32], b.degen);
               if (rsp_tdata[33] != b.none)
                  report("no_valid_match", rsp_tdata[33], b.none);
            end
         end
         if (req_tvalid && req_tready) begin
            okl = map_x(num_l, den_l, ofs_l, req_tdata[15:0], req_tdata[31:16], xl);
            okr = map_x(num_r, den_r, ofs_r, req_tdata[47:32], req_tdata[63:48], xr);
            if (okl && okr) begin
               d = xl - xr;
               if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
               if (d < -64'sh80000000) d = -64'sh80000000;
               if ($signed(d[31:0]) < run_min) run_min = d[31:0];
               if ($signed(d[31:0]) > run_max) run_max = d[31:0];
               any_ok = 1;
            end else begin
               degen_seen = 1;
            end
            if (req_tlast) begin
               if (any_ok) begin
                  b.lo = sat16(run_min >= 0 ? whole(run_min) : whole(run_min) - 1);
                  b.hi = sat16(run_max >= 0 ? whole(run_max) + 1 : whole(run_max));
                  b.none = 0;
               end else begin
                  b.lo = 0;
                  b.hi = 0;
                  b.none = 1;
               end
               b.degen = degen_seen;
               bounds_q.push_back(b);
               run_min = 32'sh7FFFFFFF;
               run_max = 32'sh80000000;
               any_ok = 0;
               degen_seen = 0;
            end
         end
         pending = bounds_q.size();
      end
   end
endmodule
`default_nettype wire

// ----- sim/stereo_disparity_range_tb.sv -----
// testbench top for the stereo disparity range block: clock, reset, stimulus and verdict
// uses sdr_pkg, stereo_disparity_range and stereo_disparity_range_checker
`default_nettype none
module stereo_disparity_range_tb;
   import sdr_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd6;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 170;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   bit          calm = 0;

   stereo_disparity_range dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   stereo_disparity_range_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic write_side(input bit right, input logic [31:0] h0, h1, h2,
                             h6, h7, h8);
      write_reg(right ? REG_RIGHT_NUM : REG_LEFT_NUM, {h0, h1});
      write_reg(right ? REG_RIGHT_DEN : REG_LEFT_DEN, {h6, h7});
      write_reg(right ? REG_RIGHT_OFS : REG_LEFT_OFS, {h2, h8});
   endtask

   // valid stays high across back-to-back transactions; dropped only for a gap or by drain
   task automatic send_match(input logic [15:0] lx, ly, rx, ry, input bit last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {ry, rx, ly, lx};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // an item that yields no result may still be in the divider
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] jitter(input int centre, input int span);
      return centre + $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic random_side(input bit right, input int mode);
      case (mode)
         0: write_side(right, jitter(1 << 20, 1 << 16), jitter(0, 1 << 12),
                       jitter(0, 1 << 28), jitter(0, 1 << 10), jitter(0, 1 << 10),
                       jitter(1 << 28, 1 << 20));
         1: write_side(right, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         2: write_side(right, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
         3: write_side(right, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000);
         4: write_side(right, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0,
                       32'h00000001);
         default: write_side(right, jitter(1 << 20, 1 << 18), $urandom, jitter(0, 1 << 30),
                             32'h0, 32'h0, ($urandom_range(0, 7) == 0) ? 32'h0 : 32'h1000_0000);
      endcase
   endtask

   initial begin
      int n, setlen, mode;
      logic [15:0] lx, ly;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // reset registers: identity mapping on both sides
      calm = 1;
      send_match(16'd0, 16'd0, 16'd0, 16'd0, 1);
      send_match(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1);
      send_match(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1);
      // exact negative whole-pixel disparity
      send_match(16'd0, 16'd0, 16'd16, 16'd0, 1);
      calm = 0;
      send_match(16'd32, 16'd0, 16'd16, 16'd0, 0);
      send_match(16'd5, 16'd7, 16'd3, 16'd9, 0);
      send_match(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1);
      drain();

      // zero left denominator everywhere: no usable match
      write_side(0, 32'h00100000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_match(16'd1, 16'd2, 16'd3, 16'd4, 0);
      send_match(16'd100, 16'd0, 16'd0, 16'd0, 1);
      drain();

      // denominator zero only at x = 0 on the left
      write_side(0, 32'h00100000, 32'h0, 32'h0, 32'h10000000, 32'h0, 32'h0);
      send_match(16'd0, 16'd9, 16'd3, 16'd4, 0);
      send_match(16'd16, 16'd9, 16'd3, 16'd4, 1);
      send_match(16'd0, 16'd0, 16'd8, 16'd8, 1);
      send_match(16'hFFFF, 16'h0, 16'd8, 16'd8, 1);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         mode = (ph < 5) ? ph : ((ph == 5) ? 5 : 0);
         random_side(0, mode);
         random_side(1, (ph == 4) ? 2 : (mode == 1 ? 1 : 0));
         calm = (ph == 2);
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            setlen = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                 : $urandom_range(1, 5);
            for (int k = 0; k < setlen; k++) begin
               lx = 16'($urandom);
               ly = 16'($urandom);
               if ($urandom_range(0, 1))
                  send_match(lx, ly, lx - 16'($urandom_range(0, 1024)), ly,
                             k == setlen - 1);
               else
                  send_match(lx, ly, 16'($urandom), 16'($urandom), k == setlen - 1);
               n++;
            end
         end
         drain();
      end
      calm = 0;
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
